/* hw/rtl/nsfc_pkg.sv */
// Shared types and constants for the NMEA sentence framer and checksum checker.
// Used by the front end, the request queue, the back end and the top level.
// No dependencies.
package nsfc_pkg;

  // Sentence body bound and the field widths.
  localparam int LEN_W = 7;
  localparam int KIND_W = 5;
  localparam logic [LEN_W-1:0] MAX_BODY_LEN = 7'd127;
  localparam int TITLE_LEN = 5;

  // Characters that steer the framing.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

  // Sentence kinds with special matching rules.
  localparam int NUM_KINDS = 24;
  localparam logic [KIND_W-1:0] KIND_HDT = 5'd14;
  localparam logic [KIND_W-1:0] KIND_ROT = 5'd15;
  localparam logic [KIND_W-1:0] KIND_PSAT = 5'd16;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 5'd24;

  // Title slots, slot 0 is the first body character and sits in the top byte.
  typedef logic [0:TITLE_LEN-1][7:0] title_t;

  // Known titles in kind order; short titles are padded with zero bytes.
  localparam title_t KIND_NAMES [NUM_KINDS] = '{
    "GPRMC", "GPVTG", "GPTXT", "GPGGA", "GPGSA", "GPGSV", "GPGLL",
    "GNRMC", "GNVTG", "GNGSA", "GNGGA", "GPZDA", "GNZDA", "GLZDA",
    {"HDT", 16'h0000}, {"ROT", 16'h0000}, {"PSAT", 8'h00},
    "PRDCU", "GLGSV", "GLGSA", "GLGGA", "GLRMC", "GLVTG", "GNGLL"
  };

  // Framing phase of the front end.
  typedef enum logic [1:0] {
    PH_HUNT,
    PH_BODY,
    PH_HEX1,
    PH_HEX2
  } phase_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_GOOD,
    STATUS_MISMATCH,
    STATUS_TOO_LONG
  } status_t;

  // One finished sentence passed from the front end to the back end.
  typedef struct packed {
    title_t title;
    logic [LEN_W-1:0] body_length;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
    status_t status;
  } record_t;

endpackage

/* hw/rtl/nsfc_front.sv */
// Front end of the sentence checker: frames bytes, accumulates checksum and title.
// Pushes one finished-sentence record per result into the queue.
// Depends on nsfc_pkg.
module nsfc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  input  logic              q_full,
  output logic              push,
  output nsfc_pkg::record_t push_rec
);

  nsfc_pkg::phase_t phase, phase_next;
  logic [7:0] running_xor, running_xor_next;
  nsfc_pkg::title_t title, title_next;
  logic [nsfc_pkg::LEN_W-1:0] char_count, char_count_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic address_ended, address_ended_next;
  logic accept;
  logic [3:0] digit;
  logic [7:0] received;

  // Value of a hex digit; anything but 0-9 and upper-case A-F reads as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] diff;
    begin
      diff = 8'h00;
      if (c >= nsfc_pkg::CH_ZERO && c <= nsfc_pkg::CH_NINE) begin
        diff = c - nsfc_pkg::CH_ZERO;
      end else if (c >= nsfc_pkg::CH_UPPER_A && c <= nsfc_pkg::CH_UPPER_F) begin
        diff = c - nsfc_pkg::CH_UPPER_A + 8'd10;
      end
      hex_value = diff[3:0];
    end
  endfunction

  // The front end only waits when the queue has no room.
  assign in_stall = q_full;
  assign accept = in_valid && !q_full;
  assign digit = hex_value(rx_byte);
  assign received = {high_nibble, digit};

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= nsfc_pkg::PH_HUNT;
      running_xor <= '0;
      title <= '0;
      char_count <= '0;
      high_nibble <= '0;
      address_ended <= 1'b0;
    end else begin
      phase <= phase_next;
      running_xor <= running_xor_next;
      title <= title_next;
      char_count <= char_count_next;
      high_nibble <= high_nibble_next;
      address_ended <= address_ended_next;
    end
  end

  // Next state and queue request for each accepted byte.
  always_comb begin
    phase_next = phase;
    running_xor_next = running_xor;
    title_next = title;
    char_count_next = char_count;
    high_nibble_next = high_nibble;
    address_ended_next = address_ended;
    push = 1'b0;
    push_rec.title = title;
    push_rec.body_length = char_count;
    push_rec.computed_checksum = running_xor;
    push_rec.received_checksum = received;
    push_rec.status = (received == running_xor) ? nsfc_pkg::STATUS_GOOD
                                                 : nsfc_pkg::STATUS_MISMATCH;
    if (accept) begin
      if (rx_byte == nsfc_pkg::CH_DOLLAR) begin
        // A dollar sign restarts the sentence in every phase.
        phase_next = nsfc_pkg::PH_BODY;
        running_xor_next = '0;
        title_next = '0;
        char_count_next = '0;
        high_nibble_next = '0;
        address_ended_next = 1'b0;
      end else begin
        case (phase)
          nsfc_pkg::PH_BODY: begin
            if (rx_byte == nsfc_pkg::CH_STAR) begin
              phase_next = nsfc_pkg::PH_HEX1;
            end else if (char_count >= nsfc_pkg::MAX_BODY_LEN) begin
              // Overlong body: report it now and drop the rest.
              push = 1'b1;
              push_rec.received_checksum = '0;
              push_rec.status = nsfc_pkg::STATUS_TOO_LONG;
              phase_next = nsfc_pkg::PH_HUNT;
            end else begin
              if (!address_ended && char_count < nsfc_pkg::LEN_W'(nsfc_pkg::TITLE_LEN)) begin
                title_next[char_count[2:0]] = rx_byte;
              end
              if (rx_byte == nsfc_pkg::CH_COMMA) begin
                address_ended_next = 1'b1;
              end
              running_xor_next = running_xor ^ rx_byte;
              char_count_next = char_count + 7'd1;
            end
          end
          nsfc_pkg::PH_HEX1: begin
            high_nibble_next = digit;
            phase_next = nsfc_pkg::PH_HEX2;
          end
          nsfc_pkg::PH_HEX2: begin
            push = 1'b1;
            phase_next = nsfc_pkg::PH_HUNT;
          end
          default: begin
            phase_next = nsfc_pkg::PH_HUNT;
          end
        endcase
      end
    end
  end

endmodule

/* hw/rtl/nsfc_queue.sv */
// Two-entry queue of finished-sentence records between front and back ends.
// Depends on nsfc_pkg.
module nsfc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  nsfc_pkg::record_t push_rec,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output nsfc_pkg::record_t head_rec
);

  nsfc_pkg::record_t mem [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head_rec = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count exceeds depth");

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");

  // The back end only pops a record that is there.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

/* hw/rtl/nsfc_back.sv */
// Back end of the sentence checker: classifies the title and holds the result.
// Takes records from the queue; depends on nsfc_pkg.
module nsfc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  input  nsfc_pkg::record_t head_rec,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [4:0]        sentence_kind,
  output logic [1:0]        status,
  output logic [7:0]        computed_checksum,
  output logic [7:0]        received_checksum,
  output logic [6:0]        body_length
);

  logic [nsfc_pkg::KIND_W-1:0] kind;

  // First known title that matches; HDT and ROT need a bare address field.
  function automatic logic [nsfc_pkg::KIND_W-1:0] classify(
    input nsfc_pkg::title_t t,
    input logic [nsfc_pkg::LEN_W-1:0] len
  );
    logic [nsfc_pkg::KIND_W-1:0] k_sel;
    logic k_hit;
    nsfc_pkg::title_t name;
    begin
      k_sel = nsfc_pkg::KIND_UNKNOWN;
      for (int k = nsfc_pkg::NUM_KINDS - 1; k >= 0; k--) begin
        name = nsfc_pkg::KIND_NAMES[k];
        if (nsfc_pkg::KIND_W'(k) == nsfc_pkg::KIND_HDT ||
            nsfc_pkg::KIND_W'(k) == nsfc_pkg::KIND_ROT) begin
          k_hit = (t[0:2] == name[0:2]) &&
                  (len == 7'd3 || t[3] == nsfc_pkg::CH_COMMA);
        end else if (nsfc_pkg::KIND_W'(k) == nsfc_pkg::KIND_PSAT) begin
          k_hit = (t[0:3] == name[0:3]);
        end else begin
          k_hit = (t == name);
        end
        if (k_hit) begin
          k_sel = nsfc_pkg::KIND_W'(k);
        end
      end
      classify = k_sel;
    end
  endfunction

  assign kind = classify(head_rec.title, head_rec.body_length);

  // Take a record whenever the output register is free or being emptied.
  assign pop = q_not_empty && (!out_valid || !out_stall);

  // Output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      sentence_kind <= kind;
      status <= head_rec.status;
      computed_checksum <= head_rec.computed_checksum;
      received_checksum <= head_rec.received_checksum;
      body_length <= head_rec.body_length;
    end
  end

endmodule

/* hw/rtl/nmea_sentence_framer_checker.sv */
// Top level of the NMEA 0183 sentence framer and checksum checker.
// Instantiates nsfc_front, nsfc_queue and nsfc_back; depends on nsfc_pkg.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_stall    rx_byte
//   out      out_valid / out_stall  sentence_kind, status, computed_checksum,
//                                   received_checksum, body_length
//
// One byte is taken every cycle while in_stall is low and updates the framing state.
// The edge that takes the last byte writes the record into the two-entry queue; it is
// classified into the output register when popped, which waits while out_stall holds
// a valid output register, and out_valid rises as the record is registered.
// Input stalls only when the queue is full, which takes three pending results while
// out_stall holds the output register.
// Reset (rst, synchronous) returns to hunting for a dollar sign and empties all stages.
module nmea_sentence_framer_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] sentence_kind,
  output logic [1:0] status,
  output logic [7:0] computed_checksum,
  output logic [7:0] received_checksum,
  output logic [6:0] body_length
);

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  nsfc_pkg::record_t push_rec;
  nsfc_pkg::record_t head_rec;

  // Framing and checksum accumulation.
  nsfc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .push     (q_push),
    .push_rec (push_rec)
  );

  // Decoupling queue.
  nsfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_rec  (head_rec)
  );

  // Classification and output register.
  nsfc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_not_empty       (q_not_empty),
    .head_rec          (head_rec),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .sentence_kind     (sentence_kind),
    .status            (status),
    .computed_checksum (computed_checksum),
    .received_checksum (received_checksum),
    .body_length       (body_length)
  );

endmodule
